/* src/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared widths, constants and word types of the rotation matrix to
// quaternion unit
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int SAT_HI    = (ONE > 32767) ? 32767 : ONE;
  localparam int SAT_LO    = (SAT_HI == 32767) ? -32768 : -SAT_HI;

  // signed radicand and numerator widths
  localparam int RAD_W     = IN_W + 2;
  localparam int NUM_W     = IN_W + 1;
  // root argument and root widths
  localparam int ARG_W     = RAD_W - 1 + FRAC_BITS;
  localparam int SQ_STEPS  = (ARG_W + 1) / 2;
  localparam int S_W       = SQ_STEPS - 1;
  // divider widths
  localparam int DIV_W     = S_W + 2;
  localparam int DVD_W     = NUM_W + FRAC_BITS;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_e;

  typedef struct packed {
    logic signed [IN_W-1:0] ax_x;
    logic signed [IN_W-1:0] ax_y;
    logic signed [IN_W-1:0] ax_z;
    logic signed [IN_W-1:0] ay_x;
    logic signed [IN_W-1:0] ay_y;
    logic signed [IN_W-1:0] ay_z;
    logic signed [IN_W-1:0] az_x;
    logic signed [IN_W-1:0] az_y;
    logic signed [IN_W-1:0] az_z;
  } mat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quat_x;
    logic signed [OUT_W-1:0] quat_y;
    logic signed [OUT_W-1:0] quat_z;
    logic signed [OUT_W-1:0] quat_w;
    logic                    degenerate;
  } quat_t;

  typedef struct packed {
    sel_e                    sel;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } side_t;

  typedef struct packed {
    sel_e                       sel;
    logic [S_W-1:0]             s;
    logic [2:0]                 neg;
    logic [2:0][DVD_W-1:0]      quo;
  } div_res_t;

endpackage

/* src/rmq_select.sv */
// ----------------------------------------------------------------------------
// rmq_select
// branch choice, radicand and off-diagonal numerators, one register stage
// ----------------------------------------------------------------------------
module rmq_select (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rmq_pkg::mat_t             mat_i,
  output logic                      valid_o,
  output logic [rmq_pkg::RAD_W-2:0] rad_o,
  output rmq_pkg::side_t            side_o
);

  localparam int RW = rmq_pkg::RAD_W;
  localparam int NW = rmq_pkg::NUM_W;
  localparam logic signed [RW-1:0] OneR = RW'(rmq_pkg::ONE);

  logic signed [RW-1:0] xx, yy, zz, trace, rad;
  logic [RW-2:0]        rad_d, rad_q;
  rmq_pkg::side_t       side_d, side_q;
  logic                 valid_q;

  assign xx    = RW'(mat_i.ax_x);
  assign yy    = RW'(mat_i.ay_y);
  assign zz    = RW'(mat_i.az_z);
  assign trace = xx + yy + zz;

  always_comb begin
    if (trace > 0) begin
      side_d.sel = rmq_pkg::SEL_W;
      rad        = trace + OneR;
      side_d.n0  = NW'(mat_i.ay_z) - NW'(mat_i.az_y);
      side_d.n1  = NW'(mat_i.az_x) - NW'(mat_i.ax_z);
      side_d.n2  = NW'(mat_i.ax_y) - NW'(mat_i.ay_x);
    end else if (mat_i.ax_x > mat_i.ay_y && mat_i.ax_x > mat_i.az_z) begin
      side_d.sel = rmq_pkg::SEL_X;
      rad        = OneR + xx - yy - zz;
      side_d.n0  = NW'(mat_i.ax_y) + NW'(mat_i.ay_x);
      side_d.n1  = NW'(mat_i.az_x) + NW'(mat_i.ax_z);
      side_d.n2  = NW'(mat_i.ay_z) - NW'(mat_i.az_y);
    end else if (mat_i.ay_y > mat_i.az_z) begin
      side_d.sel = rmq_pkg::SEL_Y;
      rad        = OneR - xx + yy - zz;
      side_d.n0  = NW'(mat_i.ax_y) + NW'(mat_i.ay_x);
      side_d.n1  = NW'(mat_i.ay_z) + NW'(mat_i.az_y);
      side_d.n2  = NW'(mat_i.az_x) - NW'(mat_i.ax_z);
    end else begin
      side_d.sel = rmq_pkg::SEL_Z;
      rad        = OneR - xx - yy + zz;
      side_d.n0  = NW'(mat_i.az_x) + NW'(mat_i.ax_z);
      side_d.n1  = NW'(mat_i.ay_z) + NW'(mat_i.az_y);
      side_d.n2  = NW'(mat_i.ax_y) - NW'(mat_i.ay_x);
    end
    // negative radicand clamps to zero
    rad_d = rad[RW-1] ? '0 : rad[RW-2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

/* src/rmq_sqrt.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined integer square root, one result bit per stage, root halved
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rmq_pkg::RAD_W-2:0] rad_i,
  input  rmq_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [rmq_pkg::S_W-1:0]   s_o,
  output rmq_pkg::side_t            side_o
);

  localparam int AW = rmq_pkg::ARG_W;
  localparam int NS = rmq_pkg::SQ_STEPS;

  logic [AW:0]     a_q   [NS];
  logic [AW:0]     res_q [NS];
  rmq_pkg::side_t  side_q[NS];
  logic [NS-1:0]   valid_q;

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [AW:0]    a_in, res_in, bitv, sum, a_d, res_d;
    rmq_pkg::side_t side_in;
    logic           v_in;

    if (k == 0) begin : g_first
      assign a_in    = (AW + 1)'({rad_i, {rmq_pkg::FRAC_BITS{1'b0}}});
      assign res_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign a_in    = a_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = valid_q[k-1];
    end

    assign bitv = (AW + 1)'(1) << (2 * (NS - 1 - k));
    assign sum  = res_in + bitv;

    always_comb begin
      if (a_in >= sum) begin
        a_d   = a_in - sum;
        res_d = (res_in >> 1) + bitv;
      end else begin
        a_d   = a_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]    <= a_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign s_o     = res_q[NS-1][rmq_pkg::S_W:1];
  assign side_o  = side_q[NS-1];

endmodule

/* src/rmq_div.sv */
// ----------------------------------------------------------------------------
// rmq_div
// three-lane restoring divider, magnitude over four times the root, one
// quotient bit per stage after a sign and scaling stage
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [rmq_pkg::S_W-1:0] s_i,
  input  rmq_pkg::side_t          side_i,
  output logic                    valid_o,
  output rmq_pkg::div_res_t       res_o
);

  localparam int DW = rmq_pkg::DIV_W;
  localparam int QW = rmq_pkg::DVD_W;
  localparam int NW = rmq_pkg::NUM_W;

  // sign and scaling stage
  logic                   pv_q;
  logic [DW-1:0]          pd_q;
  rmq_pkg::sel_e          psel_q;
  logic [rmq_pkg::S_W-1:0] ps_q;
  logic [2:0]             pneg_q;
  logic [2:0][QW-1:0]     pdvd_q;
  logic [2:0][NW-1:0]     num;
  logic [2:0]             neg_d;
  logic [2:0][QW-1:0]     dvd_d;

  assign num = {side_i.n2, side_i.n1, side_i.n0};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      neg_d[l] = num[l][NW-1];
      dvd_d[l] = {(neg_d[l] ? (~num[l] + NW'(1)) : num[l]),
                  {rmq_pkg::FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q   <= {s_i, 2'b00};
      psel_q <= side_i.sel;
      ps_q   <= s_i;
      pneg_q <= neg_d;
      pdvd_q <= dvd_d;
    end
  end

  // quotient bit stages
  logic [QW-1:0]           v_q;
  logic [DW-1:0]           d_q   [QW];
  rmq_pkg::sel_e           sel_q [QW];
  logic [rmq_pkg::S_W-1:0] s_q   [QW];
  logic [2:0]              neg_q [QW];
  logic [2:0][DW-1:0]      rem_q [QW];
  logic [2:0][QW-1:0]      quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                    v_in;
    logic [DW-1:0]           d_in;
    rmq_pkg::sel_e           sel_in;
    logic [rmq_pkg::S_W-1:0] s_in;
    logic [2:0]              neg_in;
    logic [2:0][DW-1:0]      rem_in, rem_d;
    logic [2:0][QW-1:0]      quo_in, quo_d;

    if (k == 0) begin : g_first
      assign v_in   = pv_q;
      assign d_in   = pd_q;
      assign sel_in = psel_q;
      assign s_in   = ps_q;
      assign neg_in = pneg_q;
      assign rem_in = '0;
      assign quo_in = pdvd_q;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign d_in   = d_q[k-1];
      assign sel_in = sel_q[k-1];
      assign s_in   = s_q[k-1];
      assign neg_in = neg_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [DW:0] trial;
      for (int l = 0; l < 3; l++) begin
        trial = {rem_in[l], quo_in[l][QW-1]};
        if (trial >= {1'b0, d_in}) begin
          rem_d[l] = DW'(trial - {1'b0, d_in});
          quo_d[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[DW-1:0];
          quo_d[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k]   <= d_in;
        sel_q[k] <= sel_in;
        s_q[k]   <= s_in;
        neg_q[k] <= neg_in;
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign valid_o   = v_q[QW-1];
  assign res_o.sel = sel_q[QW-1];
  assign res_o.s   = s_q[QW-1];
  assign res_o.neg = neg_q[QW-1];
  assign res_o.quo = quo_q[QW-1];

endmodule

/* src/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// rotation matrix in Q1.14 to unit quaternion, Shepperd branch choice
//
//   channel  | valid        | stall        | word
//   ---------+--------------+--------------+---------------------
//   input    | in_valid_i   | in_stall_o   | in_data_i  (mat_t)
//   output   | out_valid_o  | out_stall_i  | out_data_o (quat_t)
//
// one word per cycle while the pipeline is not held; stages: branch choice, 16 root stages,
// a scaling stage, 31 divider stages and the output register
// the whole pipeline holds while a finished word waits under out_stall_i
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rmq_pkg::mat_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rmq_pkg::quat_t out_data_o
);

  localparam int QW = rmq_pkg::DVD_W;
  localparam int OW = rmq_pkg::OUT_W;
  localparam logic [QW-1:0] PosLim = QW'(rmq_pkg::SAT_HI);
  localparam logic [QW-1:0] NegLim = QW'(-rmq_pkg::SAT_LO);

  logic                        en;
  logic                        sel_v, sq_v, dv_v;
  logic [rmq_pkg::RAD_W-2:0]   rad;
  rmq_pkg::side_t              sel_side, sq_side;
  logic [rmq_pkg::S_W-1:0]     sq_s;
  rmq_pkg::div_res_t           dres;
  logic                        out_v_q;
  rmq_pkg::quat_t              out_d, out_q;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  rmq_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (in_data_i),
    .valid_o (sel_v),
    .rad_o   (rad),
    .side_o  (sel_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sel_v),
    .rad_i   (rad),
    .side_i  (sel_side),
    .valid_o (sq_v),
    .s_o     (sq_s),
    .side_o  (sq_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .s_i     (sq_s),
    .side_i  (sq_side),
    .valid_o (dv_v),
    .res_o   (dres)
  );

  // saturation and placement
  always_comb begin
    logic [2:0][OW-1:0] c;
    logic [OW-1:0]      big;
    for (int l = 0; l < 3; l++) begin
      if (dres.neg[l]) begin
        c[l] = (dres.quo[l] > NegLim) ? OW'(rmq_pkg::SAT_LO) : OW'(~dres.quo[l] + QW'(1));
      end else begin
        c[l] = (dres.quo[l] > PosLim) ? OW'(rmq_pkg::SAT_HI) : dres.quo[l][OW-1:0];
      end
    end
    big = (32'(dres.s) > 32'(rmq_pkg::SAT_HI)) ? OW'(rmq_pkg::SAT_HI) : OW'(dres.s);
    case (dres.sel)
      rmq_pkg::SEL_W: begin
        out_d.quat_w = big;  out_d.quat_x = c[0]; out_d.quat_y = c[1]; out_d.quat_z = c[2];
      end
      rmq_pkg::SEL_X: begin
        out_d.quat_x = big;  out_d.quat_y = c[0]; out_d.quat_z = c[1]; out_d.quat_w = c[2];
      end
      rmq_pkg::SEL_Y: begin
        out_d.quat_y = big;  out_d.quat_x = c[0]; out_d.quat_z = c[1]; out_d.quat_w = c[2];
      end
      default: begin
        out_d.quat_z = big;  out_d.quat_x = c[0]; out_d.quat_y = c[1]; out_d.quat_w = c[2];
      end
    endcase
    out_d.degenerate = (dres.s == '0);
    if (out_d.degenerate) begin
      out_d.quat_x = '0;
      out_d.quat_y = '0;
      out_d.quat_z = '0;
      out_d.quat_w = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_stall_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to a waiting output word");

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.quat_x == '0 && out_data_o.quat_y == '0 &&
      out_data_o.quat_z == '0 && out_data_o.quat_w == '0)
    else $error("degenerate word with nonzero components");

  a_w_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(out_data_o.quat_w) <= $signed(OW'(rmq_pkg::SAT_HI)) &&
      $signed(out_data_o.quat_w) >= $signed(OW'(rmq_pkg::SAT_LO)))
    else $error("scalar component out of range");

endmodule

/* tb/sv/rotation_matrix_to_quaternion_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// self-checking bench: matrices go in through a bursty driver, quaternions
// are compared field by field against a behavioural Shepperd conversion
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;

  localparam int LATENCY = 50;
  localparam int WATCHDOG_LIMIT = 4000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  rmq_pkg::mat_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  rmq_pkg::quat_t out_data_o;

  rmq_pkg::mat_t  pending_mats[$];
  rmq_pkg::quat_t expected_quats[$];
  int    errors = 0;
  int    quiet_cycles = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  int    stall_mode = 0;
  int    stall_phase = 0;
  bit    stim_done = 1'b0;

  rotation_matrix_to_quaternion_unit dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(longint v);
    if (v > rmq_pkg::SAT_HI) return rmq_pkg::SAT_HI;
    if (v < rmq_pkg::SAT_LO) return rmq_pkg::SAT_LO;
    return v;
  endfunction

  function automatic longint quarter_quot(longint num, longint unsigned s);
    longint unsigned mag = (num < 0) ? -num : num;
    longint q = longint'((mag << rmq_pkg::FRAC_BITS) / (s * 4));
    return clip((num < 0) ? -q : q);
  endfunction

  function automatic rmq_pkg::quat_t to_quaternion(rmq_pkg::mat_t m);
    longint xx = m.ax_x, xy = m.ax_y, xz = m.ax_z;
    longint yx = m.ay_x, yy = m.ay_y, yz = m.ay_z;
    longint zx = m.az_x, zy = m.az_y, zz = m.az_z;
    longint tr = xx + yy + zz;
    longint rad, n0, n1, n2, a, b, c, big;
    longint unsigned s;
    rmq_pkg::sel_e sel;
    rmq_pkg::quat_t q = '0;
    if (tr > 0) begin
      sel = rmq_pkg::SEL_W; rad = tr + rmq_pkg::ONE;
      n0 = yz - zy; n1 = zx - xz; n2 = xy - yx;
    end else if (xx > yy && xx > zz) begin
      sel = rmq_pkg::SEL_X; rad = rmq_pkg::ONE + xx - yy - zz;
      n0 = xy + yx; n1 = zx + xz; n2 = yz - zy;
    end else if (yy > zz) begin
      sel = rmq_pkg::SEL_Y; rad = rmq_pkg::ONE - xx + yy - zz;
      n0 = xy + yx; n1 = yz + zy; n2 = zx - xz;
    end else begin
      sel = rmq_pkg::SEL_Z; rad = rmq_pkg::ONE - xx - yy + zz;
      n0 = zx + xz; n1 = yz + zy; n2 = xy - yx;
    end
    if (rad < 0) rad = 0;
    s = int_sqrt(unsigned'(rad) << rmq_pkg::FRAC_BITS) >> 1;
    if (s == 0) begin
      q.degenerate = 1'b1;
      return q;
    end
    a = quarter_quot(n0, s);
    b = quarter_quot(n1, s);
    c = quarter_quot(n2, s);
    big = clip(longint'(s));
    case (sel)
      rmq_pkg::SEL_W: begin
        q.quat_w = 16'(big); q.quat_x = 16'(a); q.quat_y = 16'(b); q.quat_z = 16'(c);
      end
      rmq_pkg::SEL_X: begin
        q.quat_x = 16'(big); q.quat_y = 16'(a); q.quat_z = 16'(b); q.quat_w = 16'(c);
      end
      rmq_pkg::SEL_Y: begin
        q.quat_y = 16'(big); q.quat_x = 16'(a); q.quat_z = 16'(b); q.quat_w = 16'(c);
      end
      default: begin
        q.quat_z = 16'(big); q.quat_x = 16'(a); q.quat_y = 16'(b); q.quat_w = 16'(c);
      end
    endcase
    return q;
  endfunction

  function automatic logic [15:0] any_elem();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      5, 6: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic rmq_pkg::mat_t diag_mat(int d0, int d1, int d2);
    rmq_pkg::mat_t m = '0;
    m.ax_x = 16'(d0); m.ay_y = 16'(d1); m.az_z = 16'(d2);
    return m;
  endfunction

  // roughly orthonormal matrix from a random quaternion
  function automatic rmq_pkg::mat_t rotation_mat();
    real w = $urandom_range(0, 2000) - 1000.0, x = $urandom_range(0, 2000) - 1000.0;
    real y = $urandom_range(0, 2000) - 1000.0, z = $urandom_range(0, 2000) - 1000.0;
    real n = w * w + x * x + y * y + z * z;
    real k;
    rmq_pkg::mat_t m;
    if (n < 1.0) n = 1.0;
    k = 16384.0 * 2.0 / n;
    m.ax_x = 16'($rtoi(16384.0 - k * (y * y + z * z)));
    m.ax_y = 16'($rtoi(k * (x * y + z * w)));
    m.ax_z = 16'($rtoi(k * (x * z - y * w)));
    m.ay_x = 16'($rtoi(k * (x * y - z * w)));
    m.ay_y = 16'($rtoi(16384.0 - k * (x * x + z * z)));
    m.ay_z = 16'($rtoi(k * (y * z + x * w)));
    m.az_x = 16'($rtoi(k * (x * z + y * w)));
    m.az_y = 16'($rtoi(k * (y * z - x * w)));
    m.az_z = 16'($rtoi(16384.0 - k * (x * x + y * y)));
    return m;
  endfunction

  initial begin
    rmq_pkg::mat_t m;
    pending_mats.push_back(diag_mat(16384, 16384, 16384));
    pending_mats.push_back(diag_mat(16384, -16384, -16384));
    pending_mats.push_back(diag_mat(-16384, 16384, -16384));
    pending_mats.push_back(diag_mat(-16384, -16384, 16384));
    pending_mats.push_back(diag_mat(-16384, -16384, -16384));
    pending_mats.push_back(diag_mat(0, 0, 0));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768));
    pending_mats.push_back(diag_mat(32767, 32767, 32767));
    pending_mats.push_back(diag_mat(32767, -32768, -32768));
    pending_mats.push_back(diag_mat(-32768, -32768, 32767));
    pending_mats.push_back(diag_mat(-16384, 0, 0));
    pending_mats.push_back(diag_mat(5, 5, -10));
    m = '1;
    pending_mats.push_back(m);
    m = {9{16'h7fff}};
    pending_mats.push_back(m);
    m = {9{16'h8000}};
    pending_mats.push_back(m);
    m = diag_mat(-32768, 0, 0);
    m.ax_y = 16'h7fff; m.ay_x = 16'h7fff; m.az_x = 16'h8000; m.ax_z = 16'h8000;
    pending_mats.push_back(m);
    m = diag_mat(1, 0, 0);
    m.ay_z = 16'h7fff; m.az_y = 16'h8000;
    pending_mats.push_back(m);
    repeat (1850) begin
      if ($urandom_range(0, 3) != 0) begin
        m = rotation_mat();
      end else begin
        m.ax_x = any_elem(); m.ax_y = any_elem(); m.ax_z = any_elem();
        m.ay_x = any_elem(); m.ay_y = any_elem(); m.ay_z = any_elem();
        m.az_x = any_elem(); m.az_y = any_elem(); m.az_z = any_elem();
      end
      pending_mats.push_back(m);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_quats.push_back(to_quaternion(in_data_i));
        void'(pending_mats.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_mats.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_mats[0];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
          if (pending_mats.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_quats.size() == 0) begin
          $error("quaternion word with none expected");
          errors++;
        end else begin
          rmq_pkg::quat_t e;
          e = expected_quats.pop_front();
          if (out_data_o.quat_x !== e.quat_x) begin
            $error("quat_x: expected %0d, actual %0d", e.quat_x, out_data_o.quat_x);
            errors++;
          end
          if (out_data_o.quat_y !== e.quat_y) begin
            $error("quat_y: expected %0d, actual %0d", e.quat_y, out_data_o.quat_y);
            errors++;
          end
          if (out_data_o.quat_z !== e.quat_z) begin
            $error("quat_z: expected %0d, actual %0d", e.quat_z, out_data_o.quat_z);
            errors++;
          end
          if (out_data_o.quat_w !== e.quat_w) begin
            $error("quat_w: expected %0d, actual %0d", e.quat_w, out_data_o.quat_w);
            errors++;
          end
          if (out_data_o.degenerate !== e.degenerate) begin
            $error("degenerate: expected %0b, actual %0b", e.degenerate,
                   out_data_o.degenerate);
            errors++;
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 == 199) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= (stall_phase % 7 < 3);
        default: out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rotation_matrix_to_quaternion_unit test failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_quats.size() == 0);
    repeat (LATENCY * 2) @(posedge clk_i);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("rotation_matrix_to_quaternion_unit test passed");
    end else begin
      $display("rotation_matrix_to_quaternion_unit test failed");
    end
    $finish;
  end

endmodule

/* rotation_matrix_to_quaternion_unit.f */
src/rmq_pkg.sv
src/rmq_select.sv
src/rmq_sqrt.sv
src/rmq_div.sv
src/rotation_matrix_to_quaternion_unit.sv
tb/sv/rotation_matrix_to_quaternion_unit_tb.sv
